/* design/tpcd_pkg.sv */
// Shared constants, state encoding and result record for the triangle coverage and depth block.
package tpcd_pkg;

  localparam int SubpixelBits = 4;
  localparam int SubHalf      = 1 << SubpixelBits;
  localparam int SubOne       = 1 << (SubpixelBits + 1);

  localparam int CoordW  = 16;
  localparam int ZW      = 24;
  localparam int InvWW   = 24;
  localparam int PixW    = 9;
  localparam int CfgW    = 10;
  localparam int CfgIdxW = 2;
  localparam int WgtW    = 16;
  localparam int SlotW   = 2;
  localparam int NumSlots = 3;

  localparam int EdgeW   = CoordW + 2;
  localparam int MulAW   = 19;
  localparam int MulBW   = 25;
  localparam int MulPW   = MulAW + MulBW;
  localparam int CrossW  = 37;
  localparam int ClassW  = 40;
  localparam int WtW     = 36;
  localparam int WtSplit = 18;
  localparam int AccW    = 62;
  localparam int IdxMinW = PixW + CfgW + 1;

  localparam int DivNW    = 62;
  localparam int DivDW    = 40;
  localparam int DivQW    = 24;
  localparam int NormBits = 40;
  localparam int WgtFrac  = 15;

  localparam int EdgeSteps = 6;
  localparam int MacSteps  = 12;

  localparam logic [ZW-1:0]   DepthMax = {1'b0, {(ZW-1){1'b1}}};
  localparam logic [CfgW-1:0] CfgSizeReset = 10'd512;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpSample = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHeight = 2'd1;

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_BOX   = 13'b0000000000100,
    S_EDGE  = 13'b0000000001000,
    S_CLASS = 13'b0000000010000,
    S_MAC   = 13'b0000000100000,
    S_ZDIV  = 13'b0000001000000,
    S_RD    = 13'b0000010000000,
    S_CMP   = 13'b0000100000000,
    S_PSUM  = 13'b0001000000000,
    S_PNORM = 13'b0010000000000,
    S_WDIV  = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_e;

  typedef struct packed {
    logic                          covered;
    logic                          depth_written;
    logic [ZW-1:0]                 fragment_depth;
    logic [NumSlots-1:0][WgtW-1:0] weight;
    logic [CfgW-1:0]               box_min_x;
    logic [CfgW-1:0]               box_min_y;
    logic [CfgW-1:0]               box_end_x;
    logic [CfgW-1:0]               box_end_y;
  } result_t;

endpackage

/* design/tpcd_ram.sv */
// Generic single-port synchronous RAM with registered read data.
module tpcd_ram #(
  parameter int W     = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [W-1:0]             wdata_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/tpcd_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module tpcd_div #(
  parameter int NW = 62,
  parameter int DW = 40,
  parameter int QW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o
);

  localparam int SW = DW + QW - 1;
  localparam int MW = (SW > NW) ? SW : NW;
  localparam int CW = $clog2(QW + 1);

  logic [NW-1:0] rem_q;
  logic [SW-1:0] dsh_q;
  logic [QW-1:0] quot_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [MW-1:0] rem_ext;
  logic [MW-1:0] dsh_ext;
  logic [MW-1:0] diff;
  logic          ge;

  assign rem_ext = MW'(rem_q);
  assign dsh_ext = MW'(dsh_q);
  assign ge      = rem_ext >= dsh_ext;
  assign diff    = rem_ext - dsh_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dsh_q  <= SW'(divisor_i) << (QW - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= diff[NW-1:0];
      end
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* design/triangle_pixel_coverage_depth_test.sv */
// Triangle coverage, depth interpolation and depth-buffer test, top level.
// Load transfer: returns the bounding box. Sample transfer: edge and inside tests, and
// when covered the in-view depth test and weights, using the shared divider that runs once
// for depth and once per corner weight, plus a one-bit-per-cycle normalizing shift.
// One item is in flight at a time; a finished result waits in the output register.
// After reset every address of the depth store is written with maximum depth before the first input is taken.
module triangle_pixel_coverage_depth_test #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 operation_i,
  input  logic [tpcd_pkg::SlotW-1:0]           vertex_slot_i,
  input  logic signed [tpcd_pkg::CoordW-1:0]   vertex_x_i,
  input  logic signed [tpcd_pkg::CoordW-1:0]   vertex_y_i,
  input  logic signed [tpcd_pkg::ZW-1:0]       vertex_depth_i,
  input  logic [tpcd_pkg::InvWW-1:0]           vertex_inv_w_i,
  input  logic [tpcd_pkg::PixW-1:0]            pixel_x_i,
  input  logic [tpcd_pkg::PixW-1:0]            pixel_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 covered_o,
  output logic                                 depth_written_o,
  output logic signed [tpcd_pkg::ZW-1:0]       fragment_depth_o,
  output logic [tpcd_pkg::WgtW-1:0]            weight_first_o,
  output logic [tpcd_pkg::WgtW-1:0]            weight_second_o,
  output logic [tpcd_pkg::WgtW-1:0]            weight_third_o,
  output logic [tpcd_pkg::CfgW-1:0]            box_min_x_o,
  output logic [tpcd_pkg::CfgW-1:0]            box_min_y_o,
  output logic [tpcd_pkg::CfgW-1:0]            box_end_x_o,
  output logic [tpcd_pkg::CfgW-1:0]            box_end_y_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tpcd_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [tpcd_pkg::CfgW-1:0]            cfg_data_i
);

  import tpcd_pkg::*;

  localparam int StoreSize = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(StoreSize);
  localparam int IW = (AW > IdxMinW) ? AW : IdxMinW;

  function automatic logic signed [EdgeW-1:0] dbl(input logic [CoordW-1:0] v);
    return {v[CoordW-1], v, 1'b0};
  endfunction

  function automatic logic [2*CfgW-1:0] box_axis(input logic [CoordW-1:0] a,
                                                 input logic [CoordW-1:0] b,
                                                 input logic [CoordW-1:0] c,
                                                 input logic [CfgW-1:0] size);
    logic signed [CoordW-1:0] lo;
    logic signed [CoordW-1:0] hi;
    logic signed [EdgeW-1:0]  f;
    logic signed [EdgeW-1:0]  e;
    logic signed [EdgeW-1:0]  sz;
    logic [CfgW-1:0]          fo;
    logic [CfgW-1:0]          eo;
    lo = $signed(a);
    hi = $signed(a);
    if ($signed(b) < lo) lo = $signed(b);
    if ($signed(c) < lo) lo = $signed(c);
    if ($signed(b) > hi) hi = $signed(b);
    if ($signed(c) > hi) hi = $signed(c);
    f  = (dbl(lo) - $signed(EdgeW'(SubHalf))) >>> (SubpixelBits + 1);
    e  = (dbl(hi) + $signed(EdgeW'(SubHalf + SubOne - 1))) >>> (SubpixelBits + 1);
    sz = $signed(EdgeW'(size));
    if (f < 0) fo = '0;
    else if (f > sz) fo = size;
    else fo = f[CfgW-1:0];
    if (e < 0) eo = '0;
    else if (e > sz) eo = size;
    else eo = e[CfgW-1:0];
    if (eo < fo) eo = fo;
    return {eo, fo};
  endfunction

  state_e state_q;
  logic [3:0]    k_q;
  logic [1:0]    widx_q;
  logic          div_wait_q;
  logic [AW-1:0] clr_cnt_q;
  logic          out_valid_q;
  logic [CfgW-1:0] cfg_w_q;
  logic [CfgW-1:0] cfg_h_q;
  logic [CfgW-1:0] eff_w;
  logic [CfgW-1:0] eff_h;

  logic [CoordW-1:0] cx_q [NumSlots];
  logic [CoordW-1:0] cy_q [NumSlots];
  logic [ZW-1:0]     cz_q [NumSlots];
  logic [InvWW-1:0]  cw_q [NumSlots];

  logic signed [EdgeW-1:0] dx1_q, dy1_q, dx2_q, dy2_q, ex_q, ey_q;
  logic signed [EdgeW-1:0] px_c, py_c;
  logic [CrossW-1:0] ux_q, uy_q, area_q;
  logic [WtW-1:0]    wt_q [NumSlots];
  logic [WtW-1:0]    areap_q;
  logic [AccW-1:0]   num_q;
  logic [AccW-1:0]   n_q [NumSlots];
  logic [AccW-1:0]   den_q;
  logic [AccW-1:0]   den_c;
  logic [AW-1:0]     addr_q;
  logic              inview_q;
  logic [IW-1:0]     idx_c;
  logic              inview_c;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] mul_p_q;
  logic [AccW-1:0]         mul_ext;
  logic [CrossW-1:0]       mul_cross;
  logic [3:0]              kp;

  logic signed [ClassW-1:0] cw0, cw1, cw2, carea;
  logic                     covered_c;

  logic [WtW-1:0]   sel_wt;
  logic [ZW-1:0]    sel_z;
  logic [InvWW-1:0] sel_w;
  logic [AccW-1:0]  sel_n;

  logic             div_start;
  logic [DivNW-1:0] div_dividend;
  logic [DivDW-1:0] div_divisor;
  logic             div_done;
  logic [DivQW-1:0] div_quot;

  logic          mem_en, mem_we;
  logic [AW-1:0] mem_addr;
  logic [ZW-1:0] mem_wdata, mem_rdata;
  logic          pass;

  logic [2*CfgW-1:0] box_x, box_y;

  result_t res_q;
  result_t out_q;

  logic in_acc, out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (cfg_w_q == '0) eff_w = CfgW'(1);
    else if (32'(cfg_w_q) > MAX_WIDTH) eff_w = CfgW'(MAX_WIDTH);
    else eff_w = cfg_w_q;
    if (cfg_h_q == '0) eff_h = CfgW'(1);
    else if (32'(cfg_h_q) > MAX_HEIGHT) eff_h = CfgW'(MAX_HEIGHT);
    else eff_h = cfg_h_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CfgSizeReset;
      cfg_h_q <= CfgSizeReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgWidth:  cfg_w_q <= cfg_data_i;
        CfgHeight: cfg_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) begin
        cx_q[i] <= '0;
        cy_q[i] <= '0;
        cz_q[i] <= '0;
        cw_q[i] <= '0;
      end
    end else if (in_acc && operation_i == OpLoad && vertex_slot_i < SlotW'(NumSlots)) begin
      cx_q[vertex_slot_i] <= vertex_x_i;
      cy_q[vertex_slot_i] <= vertex_y_i;
      cz_q[vertex_slot_i] <= vertex_depth_i;
      cw_q[vertex_slot_i] <= vertex_inv_w_i;
    end
  end

  // sample point and store address
  assign px_c = $signed(EdgeW'({pixel_x_i, 1'b1}) << SubpixelBits);
  assign py_c = $signed(EdgeW'({pixel_y_i, 1'b1}) << SubpixelBits);
  assign idx_c = IW'(pixel_x_i) + IW'(pixel_y_i) * IW'(eff_w);
  assign inview_c = (CfgW'(pixel_x_i) < eff_w) && (CfgW'(pixel_y_i) < eff_h) &&
                    (32'(idx_c) < StoreSize);

  assign box_x = box_axis(cx_q[0], cx_q[1], cx_q[2], eff_w);
  assign box_y = box_axis(cy_q[0], cy_q[1], cy_q[2], eff_h);

  // shared multiplier operands
  always_comb begin
    case (k_q[3:2])
      2'd0: begin sel_wt = wt_q[0]; sel_z = cz_q[0]; sel_w = cw_q[0]; end
      2'd1: begin sel_wt = wt_q[1]; sel_z = cz_q[1]; sel_w = cw_q[1]; end
      2'd2: begin sel_wt = wt_q[2]; sel_z = cz_q[2]; sel_w = cw_q[2]; end
      default: begin sel_wt = '0; sel_z = '0; sel_w = '0; end
    endcase
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_EDGE: begin
        case (k_q)
          4'd0: begin mul_a = MulAW'(dx1_q); mul_b = MulBW'(ey_q); end
          4'd1: begin mul_a = MulAW'(ex_q);  mul_b = MulBW'(dy1_q); end
          4'd2: begin mul_a = MulAW'(ex_q);  mul_b = MulBW'(dy2_q); end
          4'd3: begin mul_a = MulAW'(dx2_q); mul_b = MulBW'(ey_q); end
          4'd4: begin mul_a = MulAW'(dx2_q); mul_b = MulBW'(dy1_q); end
          4'd5: begin mul_a = MulAW'(dx1_q); mul_b = MulBW'(dy2_q); end
          default: ;
        endcase
      end
      S_MAC: begin
        mul_a = k_q[0] ? $signed({1'b0, sel_wt[WtW-1:WtSplit]})
                       : $signed({1'b0, sel_wt[WtSplit-1:0]});
        mul_b = k_q[1] ? $signed({1'b0, sel_w}) : $signed({sel_z[ZW-1], sel_z});
      end
      default: ;
    endcase
  end

  assign kp        = k_q - 4'd1;
  assign mul_ext   = {{(AccW-MulPW){mul_p_q[MulPW-1]}}, mul_p_q};
  assign mul_cross = mul_p_q[CrossW-1:0];

  // triangle orientation and inside test
  always_comb begin
    cw0   = $signed(ClassW'($signed(area_q))) - $signed(ClassW'($signed(ux_q)))
            - $signed(ClassW'($signed(uy_q)));
    cw1   = $signed(ClassW'($signed(uy_q)));
    cw2   = $signed(ClassW'($signed(ux_q)));
    carea = $signed(ClassW'($signed(area_q)));
    if (area_q[CrossW-1]) begin
      cw0   = -cw0;
      cw1   = -cw1;
      cw2   = -cw2;
      carea = -carea;
    end
    covered_c = (area_q != '0) && !cw0[ClassW-1] && !cw1[ClassW-1] && !cw2[ClassW-1];
  end

  assign den_c = n_q[0] + n_q[1] + n_q[2];

  always_comb begin
    case (widx_q)
      2'd0:    sel_n = n_q[0];
      2'd1:    sel_n = n_q[1];
      2'd2:    sel_n = n_q[2];
      default: sel_n = '0;
    endcase
    if (state_q == S_ZDIV) begin
      div_dividend = {num_q[AccW-2:0], 1'b0} + AccW'(areap_q) + (AccW'(areap_q) << ZW);
      div_divisor  = DivDW'({areap_q, 1'b0});
    end else begin
      div_dividend = (sel_n << WgtFrac) + (den_q >> 1);
      div_divisor  = den_q[DivDW-1:0];
    end
  end

  assign div_start = (state_q == S_ZDIV || state_q == S_WDIV) && !div_wait_q;

  tpcd_div #(
    .NW(DivNW),
    .DW(DivDW),
    .QW(DivQW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign pass = $signed(res_q.fragment_depth) < $signed(mem_rdata);

  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = addr_q;
    mem_wdata = res_q.fragment_depth;
    case (state_q)
      S_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_q;
        mem_wdata = DepthMax;
      end
      S_RD:  mem_en = 1'b1;
      S_CMP: begin
        mem_en = pass;
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  tpcd_ram #(
    .W    (ZW),
    .DEPTH(StoreSize)
  ) u_store (
    .clk_i  (clk_i),
    .en_i   (mem_en),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      k_q         <= '0;
      widx_q      <= '0;
      div_wait_q  <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == AW'(StoreSize - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          k_q <= '0;
          if (in_acc) state_q <= (operation_i == OpLoad) ? S_BOX : S_EDGE;
        end
        S_BOX: state_q <= S_OUT;
        S_EDGE: begin
          k_q <= k_q + 1'b1;
          if (k_q == 4'(EdgeSteps)) state_q <= S_CLASS;
        end
        S_CLASS: begin
          k_q     <= '0;
          state_q <= covered_c ? S_MAC : S_OUT;
        end
        S_MAC: begin
          k_q <= k_q + 1'b1;
          if (k_q == 4'(MacSteps)) state_q <= S_ZDIV;
        end
        S_ZDIV: begin
          if (!div_wait_q) begin
            div_wait_q <= 1'b1;
          end else if (div_done) begin
            div_wait_q <= 1'b0;
            state_q    <= inview_q ? S_RD : S_PSUM;
          end
        end
        S_RD:  state_q <= S_CMP;
        S_CMP: state_q <= S_PSUM;
        S_PSUM: state_q <= S_PNORM;
        S_PNORM: begin
          widx_q <= '0;
          if (den_q[AccW-1:NormBits] == '0) state_q <= S_WDIV;
        end
        S_WDIV: begin
          if (!div_wait_q) begin
            div_wait_q <= 1'b1;
          end else if (div_done) begin
            div_wait_q <= 1'b0;
            widx_q     <= widx_q + 1'b1;
            if (widx_q == 2'(NumSlots - 1)) state_q <= S_OUT;
          end
        end
        S_OUT: if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    mul_p_q <= mul_a * mul_b;
    if (state_q == S_OUT && out_free) out_q <= res_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_q    <= '0;
          dx1_q    <= dbl(cx_q[1]) - dbl(cx_q[0]);
          dy1_q    <= dbl(cy_q[1]) - dbl(cy_q[0]);
          dx2_q    <= dbl(cx_q[2]) - dbl(cx_q[0]);
          dy2_q    <= dbl(cy_q[2]) - dbl(cy_q[0]);
          ex_q     <= dbl(cx_q[0]) - px_c;
          ey_q     <= dbl(cy_q[0]) - py_c;
          ux_q     <= '0;
          uy_q     <= '0;
          area_q   <= '0;
          addr_q   <= idx_c[AW-1:0];
          inview_q <= inview_c;
        end
      end
      S_BOX: begin
        res_q.box_min_x <= box_x[CfgW-1:0];
        res_q.box_end_x <= box_x[2*CfgW-1:CfgW];
        res_q.box_min_y <= box_y[CfgW-1:0];
        res_q.box_end_y <= box_y[2*CfgW-1:CfgW];
      end
      S_EDGE: begin
        if (k_q != '0) begin
          case (kp)
            4'd0: ux_q   <= ux_q + mul_cross;
            4'd1: ux_q   <= ux_q - mul_cross;
            4'd2: uy_q   <= uy_q + mul_cross;
            4'd3: uy_q   <= uy_q - mul_cross;
            4'd4: area_q <= area_q + mul_cross;
            4'd5: area_q <= area_q - mul_cross;
            default: ;
          endcase
        end
      end
      S_CLASS: begin
        if (covered_c) begin
          res_q.covered <= 1'b1;
          wt_q[0] <= cw0[WtW-1:0];
          wt_q[1] <= cw1[WtW-1:0];
          wt_q[2] <= cw2[WtW-1:0];
          areap_q <= carea[WtW-1:0];
          num_q   <= '0;
          for (int i = 0; i < NumSlots; i++) n_q[i] <= '0;
        end
      end
      S_MAC: begin
        if (k_q != '0) begin
          if (kp[1]) begin
            n_q[kp[3:2]] <= n_q[kp[3:2]] + (kp[0] ? (mul_ext << WtSplit) : mul_ext);
          end else begin
            num_q <= num_q + (kp[0] ? (mul_ext << WtSplit) : mul_ext);
          end
        end
      end
      S_ZDIV: begin
        if (div_wait_q && div_done) begin
          res_q.fragment_depth <= {~div_quot[ZW-1], div_quot[ZW-2:0]};
        end
      end
      S_CMP: if (pass) res_q.depth_written <= 1'b1;
      S_PSUM: begin
        if (den_c == '0) begin
          for (int i = 0; i < NumSlots; i++) n_q[i] <= AccW'(wt_q[i]);
          den_q <= AccW'(areap_q);
        end else begin
          den_q <= den_c;
        end
      end
      S_PNORM: begin
        if (den_q[AccW-1:NormBits] != '0) begin
          den_q <= den_q >> 1;
          for (int i = 0; i < NumSlots; i++) n_q[i] <= n_q[i] >> 1;
        end
      end
      S_WDIV: begin
        if (div_wait_q && div_done) res_q.weight[widx_q] <= div_quot[WgtW-1:0];
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign covered_o        = out_q.covered;
  assign depth_written_o  = out_q.depth_written;
  assign fragment_depth_o = out_q.fragment_depth;
  assign weight_first_o   = out_q.weight[0];
  assign weight_second_o  = out_q.weight[1];
  assign weight_third_o   = out_q.weight[2];
  assign box_min_x_o      = out_q.box_min_x;
  assign box_min_y_o      = out_q.box_min_y;
  assign box_end_x_o      = out_q.box_end_x;
  assign box_end_y_o      = out_q.box_end_y;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP && mem_en) |-> (res_q.covered && inview_q))
    else $error("depth store written for a sample that is not covered or off screen");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !div_done)
    else $error("divider finished right after start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && depth_written_o) |-> covered_o)
    else $error("depth written without coverage");

endmodule

/* verif/triangle_pixel_coverage_depth_test_checker.sv */
// Checker: predicts coverage, depth test, weights and boxes, and compares every result transfer.
module triangle_pixel_coverage_depth_test_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic                               operation_i,
  input  logic [tpcd_pkg::SlotW-1:0]         vertex_slot_i,
  input  logic signed [tpcd_pkg::CoordW-1:0] vertex_x_i,
  input  logic signed [tpcd_pkg::CoordW-1:0] vertex_y_i,
  input  logic signed [tpcd_pkg::ZW-1:0]     vertex_depth_i,
  input  logic [tpcd_pkg::InvWW-1:0]         vertex_inv_w_i,
  input  logic [tpcd_pkg::PixW-1:0]          pixel_x_i,
  input  logic [tpcd_pkg::PixW-1:0]          pixel_y_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic                               covered_i,
  input  logic                               depth_written_i,
  input  logic [tpcd_pkg::ZW-1:0]            fragment_depth_i,
  input  logic [tpcd_pkg::WgtW-1:0]          weight_first_i,
  input  logic [tpcd_pkg::WgtW-1:0]          weight_second_i,
  input  logic [tpcd_pkg::WgtW-1:0]          weight_third_i,
  input  logic [tpcd_pkg::CfgW-1:0]          box_min_x_i,
  input  logic [tpcd_pkg::CfgW-1:0]          box_min_y_i,
  input  logic [tpcd_pkg::CfgW-1:0]          box_end_x_i,
  input  logic [tpcd_pkg::CfgW-1:0]          box_end_y_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [tpcd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [tpcd_pkg::CfgW-1:0]          cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  import tpcd_pkg::*;

  localparam int MaxSize   = 512;
  localparam int StoreSize = MaxSize * MaxSize;

  typedef struct {
    logic            covered;
    logic            depth_written;
    logic [ZW-1:0]   fragment_depth;
    logic [WgtW-1:0] weight[3];
    logic [CfgW-1:0] box_min_x;
    logic [CfgW-1:0] box_min_y;
    logic [CfgW-1:0] box_end_x;
    logic [CfgW-1:0] box_end_y;
  } frag_result_t;

  frag_result_t    frag_q[$];
  longint          corner_x[3];
  longint          corner_y[3];
  longint          corner_z[3];
  longint          corner_iw[3];
  logic [ZW-1:0]   zbuf[StoreSize];
  logic [CfgW-1:0] vp_width;
  logic [CfgW-1:0] vp_height;
  int              fails;

  assign fail_count_o = fails;
  assign pending_o    = frag_q.size();

  initial begin
    for (int i = 0; i < 3; i++) begin
      corner_x[i] = 0;
      corner_y[i] = 0;
      corner_z[i] = 0;
      corner_iw[i] = 0;
    end
    for (int i = 0; i < StoreSize; i++) zbuf[i] = DepthMax;
    vp_width  = CfgSizeReset;
    vp_height = CfgSizeReset;
    fails     = 0;
  end

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint eff_size(logic [CfgW-1:0] r);
    if (r < 1) return 1;
    return r > MaxSize ? MaxSize : r;
  endfunction

  function automatic void axis_box(longint c0, longint c1, longint c2, longint size,
                                   output longint first, output longint last_ex);
    longint lo, hi;
    lo = c0 < c1 ? c0 : c1;
    lo = lo < c2 ? lo : c2;
    hi = c0 > c1 ? c0 : c1;
    hi = hi > c2 ? hi : c2;
    first   = clip(floor_div(lo * 2 - SubHalf, SubOne), 0, size);
    last_ex = clip(-floor_div(-(hi * 2 + SubHalf), SubOne), 0, size);
    if (last_ex < first) last_ex = first;
  endfunction

  function automatic frag_result_t shade(logic op, logic [1:0] slot, longint vx, longint vy,
                                         longint vz, longint viw, longint pxu, longint pyu);
    frag_result_t r;
    longint w, h, bx0, bx1, by0, by1;
    longint px, py, x0, y0, dx1, dy1, dx2, dy2, ex, ey, ux, uy, area, num, z;
    longint wt[3];
    longint unsigned n[3];
    longint unsigned den;
    w = eff_size(vp_width);
    h = eff_size(vp_height);
    r.covered = 0;
    r.depth_written = 0;
    r.fragment_depth = '0;
    for (int i = 0; i < 3; i++) r.weight[i] = '0;
    r.box_min_x = '0;
    r.box_min_y = '0;
    r.box_end_x = '0;
    r.box_end_y = '0;
    if (op == OpLoad) begin
      if (slot < NumSlots) begin
        corner_x[slot] = vx;
        corner_y[slot] = vy;
        corner_z[slot] = vz;
        corner_iw[slot] = viw;
      end
      axis_box(corner_x[0], corner_x[1], corner_x[2], w, bx0, bx1);
      axis_box(corner_y[0], corner_y[1], corner_y[2], h, by0, by1);
      r.box_min_x = bx0[CfgW-1:0];
      r.box_min_y = by0[CfgW-1:0];
      r.box_end_x = bx1[CfgW-1:0];
      r.box_end_y = by1[CfgW-1:0];
      return r;
    end
    px = ((pxu << 1) | 1) << SubpixelBits;
    py = ((pyu << 1) | 1) << SubpixelBits;
    x0 = corner_x[0] * 2;
    y0 = corner_y[0] * 2;
    dx1 = corner_x[1] * 2 - x0;
    dy1 = corner_y[1] * 2 - y0;
    dx2 = corner_x[2] * 2 - x0;
    dy2 = corner_y[2] * 2 - y0;
    ex = x0 - px;
    ey = y0 - py;
    ux = dx1 * ey - ex * dy1;
    uy = ex * dy2 - dx2 * ey;
    area = dx2 * dy1 - dx1 * dy2;
    if (area == 0) return r;
    wt[0] = area - ux - uy;
    wt[1] = uy;
    wt[2] = ux;
    if (area < 0) begin
      area = -area;
      for (int i = 0; i < 3; i++) wt[i] = -wt[i];
    end
    if (wt[0] < 0 || wt[1] < 0 || wt[2] < 0) return r;
    r.covered = 1;
    num = 0;
    for (int i = 0; i < 3; i++) num += wt[i] * corner_z[i];
    z = floor_div(2 * num + area, 2 * area);
    r.fragment_depth = z[ZW-1:0];
    if (pxu < w && pyu < h) begin
      longint idx;
      idx = pxu + pyu * w;
      if (idx < StoreSize && z < longint'($signed(zbuf[idx]))) begin
        zbuf[idx] = z[ZW-1:0];
        r.depth_written = 1;
      end
    end
    den = 0;
    for (int i = 0; i < 3; i++) begin
      n[i] = longint'(wt[i]) * corner_iw[i];
      den += n[i];
    end
    if (den == 0) begin
      for (int i = 0; i < 3; i++) n[i] = wt[i];
      den = area;
    end
    while (den >= (64'd1 << NormBits)) begin
      den >>= 1;
      for (int i = 0; i < 3; i++) n[i] >>= 1;
    end
    for (int i = 0; i < 3; i++) r.weight[i] = WgtW'((n[i] * 32768 + den / 2) / den);
    return r;
  endfunction

  function automatic void compare(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: mismatch %s expected %0h actual %0h", $time, field, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin
    frag_result_t e;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgWidth) vp_width = cfg_data_i;
        else if (cfg_index_i == CfgHeight) vp_height = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i)
        frag_q.push_back(shade(operation_i, vertex_slot_i, vertex_x_i, vertex_y_i,
                               vertex_depth_i, vertex_inv_w_i, pixel_x_i, pixel_y_i));
      if (out_valid_i && !out_stall_i) begin
        if (frag_q.size() == 0) begin
          $display("%0t: mismatch result transfer expected none actual one", $time);
          fails++;
        end else begin
          e = frag_q.pop_front();
          compare("covered", e.covered, covered_i);
          compare("depth_written", e.depth_written, depth_written_i);
          compare("fragment_depth", e.fragment_depth, fragment_depth_i);
          compare("weight_first", e.weight[0], weight_first_i);
          compare("weight_second", e.weight[1], weight_second_i);
          compare("weight_third", e.weight[2], weight_third_i);
          compare("box_min_x", e.box_min_x, box_min_x_i);
          compare("box_min_y", e.box_min_y, box_min_y_i);
          compare("box_end_x", e.box_end_x, box_end_x_i);
          compare("box_end_y", e.box_end_y, box_end_y_i);
        end
      end
    end
  end

endmodule

/* verif/triangle_pixel_coverage_depth_test_test.sv */
// Testbench top: drives triangle loads, pixel samples and viewport writes, and reports the verdict.
module triangle_pixel_coverage_depth_test_test;
  import tpcd_pkg::*;

  localparam int ItemTarget = 1200;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid;
  logic                     in_stall;
  logic                     operation;
  logic [SlotW-1:0]         vertex_slot;
  logic signed [CoordW-1:0] vertex_x;
  logic signed [CoordW-1:0] vertex_y;
  logic signed [ZW-1:0]     vertex_depth;
  logic [InvWW-1:0]         vertex_inv_w;
  logic [PixW-1:0]          pixel_x;
  logic [PixW-1:0]          pixel_y;
  logic                     out_valid;
  logic                     out_stall;
  logic                     covered;
  logic                     depth_written;
  logic signed [ZW-1:0]     fragment_depth;
  logic [WgtW-1:0]          weight_first;
  logic [WgtW-1:0]          weight_second;
  logic [WgtW-1:0]          weight_third;
  logic [CfgW-1:0]          box_min_x;
  logic [CfgW-1:0]          box_min_y;
  logic [CfgW-1:0]          box_end_x;
  logic [CfgW-1:0]          box_end_y;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CfgIdxW-1:0]       cfg_index;
  logic [CfgW-1:0]          cfg_data;
  int                       fail_count;
  int                       pending;
  int                       sent;
  bit                       quiet;
  int                       vw;
  int                       vh;
  int                       stall_left;

  triangle_pixel_coverage_depth_test dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .operation_i(operation), .vertex_slot_i(vertex_slot),
    .vertex_x_i(vertex_x), .vertex_y_i(vertex_y),
    .vertex_depth_i(vertex_depth), .vertex_inv_w_i(vertex_inv_w),
    .pixel_x_i(pixel_x), .pixel_y_i(pixel_y),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .covered_o(covered), .depth_written_o(depth_written),
    .fragment_depth_o(fragment_depth),
    .weight_first_o(weight_first), .weight_second_o(weight_second),
    .weight_third_o(weight_third),
    .box_min_x_o(box_min_x), .box_min_y_o(box_min_y),
    .box_end_x_o(box_end_x), .box_end_y_o(box_end_y),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  triangle_pixel_coverage_depth_test_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .operation_i(operation), .vertex_slot_i(vertex_slot),
    .vertex_x_i(vertex_x), .vertex_y_i(vertex_y),
    .vertex_depth_i(vertex_depth), .vertex_inv_w_i(vertex_inv_w),
    .pixel_x_i(pixel_x), .pixel_y_i(pixel_y),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .covered_i(covered), .depth_written_i(depth_written),
    .fragment_depth_i(fragment_depth),
    .weight_first_i(weight_first), .weight_second_i(weight_second),
    .weight_third_i(weight_third),
    .box_min_x_i(box_min_x), .box_min_y_i(box_min_y),
    .box_end_x_i(box_end_x), .box_end_y_i(box_end_y),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // random receiver stall bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else if (!quiet && ($urandom_range(0, 511) > 160) && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  task automatic send(logic op, logic [1:0] slot, logic [15:0] sx, logic [15:0] sy,
                      logic [23:0] sz, logic [23:0] siw, logic [8:0] spx, logic [8:0] spy);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    operation <= op;
    vertex_slot <= slot;
    vertex_x <= sx;
    vertex_y <= sy;
    vertex_depth <= sz;
    vertex_inv_w <= siw;
    pixel_x <= spx;
    pixel_y <= spy;
    in_valid <= 1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent++;
  endtask

  task automatic load(logic [1:0] slot, logic [15:0] sx, logic [15:0] sy, logic [23:0] sz,
                      logic [23:0] siw);
    send(OpLoad, slot, sx, sy, sz, siw, 9'($urandom), 9'($urandom));
  endtask

  task automatic probe(int px, int py);
    send(OpSample, 2'($urandom), 16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom),
         9'(px), 9'(py));
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, int val);
    cfg_index <= idx;
    cfg_data <= CfgW'(val);
    cfg_valid <= 1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 0;
    @(posedge clk_i);
  endtask

  function automatic int clip9(int v);
    return v < 0 ? 0 : (v > 511 ? 511 : v);
  endfunction

  // triangle near a random pixel, sometimes degenerate, then samples around its box
  task automatic triangle();
    int cx, cy, span, lo_x, hi_x, lo_y, hi_y, nsamp;
    int tx[3];
    int ty[3];
    bit snap, zero_w;
    cx = $urandom_range(0, vw - 1);
    cy = $urandom_range(0, vh - 1);
    span = $urandom_range(0, 9) == 0 ? $urandom_range(16, 400) : $urandom_range(8, 96);
    snap = $urandom_range(0, 2) == 0;
    zero_w = $urandom_range(0, 7) == 0;
    lo_x = 511; hi_x = 0; lo_y = 511; hi_y = 0;
    for (int i = 0; i < 3; i++) begin
      tx[i] = cx * 16 + 8 + $urandom_range(0, 2 * span) - span;
      ty[i] = cy * 16 + 8 + $urandom_range(0, 2 * span) - span;
      if (snap) begin
        tx[i] = (tx[i] & ~15) | 8;
        ty[i] = (ty[i] & ~15) | 8;
      end
    end
    if ($urandom_range(0, 11) == 0) begin
      tx[2] = tx[0]; ty[2] = ty[0];
    end
    for (int i = 0; i < 3; i++) begin
      load(2'(i), 16'(tx[i]), 16'(ty[i]), 24'($urandom),
           zero_w ? 24'd0 : ($urandom_range(0, 3) == 0 ? 24'($urandom_range(0, 255))
                                                         : 24'($urandom)));
      if (tx[i] / 16 < lo_x) lo_x = tx[i] / 16;
      if (tx[i] / 16 > hi_x) hi_x = tx[i] / 16;
      if (ty[i] / 16 < lo_y) lo_y = ty[i] / 16;
      if (ty[i] / 16 > hi_y) hi_y = ty[i] / 16;
    end
    nsamp = $urandom_range(4, 9);
    for (int i = 0; i < nsamp; i++)
      probe(clip9($urandom_range(0, hi_x - lo_x + 2) + lo_x - 1),
            clip9($urandom_range(0, hi_y - lo_y + 2) + lo_y - 1));
  endtask

  initial begin
    int vwl[6];
    int vhl[6];
    vwl = '{512, 1, 512, 37, 1, 200};
    vhl = '{512, 1, 1, 300, 512, 200};
    rst_ni = 0;
    in_valid = 0;
    operation = OpLoad;
    vertex_slot = 0;
    vertex_x = 0;
    vertex_y = 0;
    vertex_depth = 0;
    vertex_inv_w = 0;
    pixel_x = 0;
    pixel_y = 0;
    out_stall = 0;
    stall_left = 0;
    cfg_valid = 0;
    cfg_index = CfgWidth;
    cfg_data = 0;
    sent = 0;
    quiet = 0;
    vw = 512;
    vh = 512;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // extremes, slot 3, degenerate, zero inverse w, edge-centered samples, far pixel
    load(2'd0, 16'h8000, 16'h8000, 24'h800000, 24'd0);
    load(2'd1, 16'h7fff, 16'h7fff, 24'h7fffff, 24'hffffff);
    load(2'd3, 16'h1234, 16'h4321, 24'h0, 24'h0);
    probe(0, 0);
    probe(511, 511);
    load(2'd2, 16'h7fff, 16'h8000, 24'h7fffff, 24'hffffff);
    probe(256, 256);
    probe(511, 0);
    load(2'd0, 16'd8, 16'd8, 24'h100000, 24'd0);
    load(2'd1, 16'd168, 16'd8, 24'h200000, 24'd0);
    load(2'd2, 16'd8, 16'd168, 24'hf00000, 24'd0);
    probe(0, 0);
    probe(10, 0);
    probe(0, 10);
    probe(5, 5);
    probe(5, 5);
    probe(11, 11);
    load(2'd2, 16'd88, 16'd8, 24'h0, 24'h010000);
    probe(3, 0);
    load(2'd0, 16'd8184, 16'd8184, 24'h7fffff, 24'h000001);
    load(2'd1, 16'd8200, 16'd8100, 24'h800000, 24'hffffff);
    load(2'd2, 16'd8100, 16'd8200, 24'h000000, 24'h800000);
    probe(511, 511);
    probe(510, 510);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(CfgWidth, vwl[ph]);
      cfg_write(CfgHeight, vhl[ph]);
      vw = vwl[ph];
      vh = vhl[ph];
      while (sent < 25 + (ph + 1) * (ItemTarget - 25) / 6) begin
        if (sent > ItemTarget * 85 / 100) quiet = 1;
        if ($urandom_range(0, 6) == 0)
          send(1'($urandom), 2'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
               24'($urandom), 9'($urandom), 9'($urandom));
        else
          triangle();
        if (ph == 2 && $urandom_range(0, 40) == 0) drain();
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(8 * 6000000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
design/tpcd_pkg.sv
design/tpcd_ram.sv
design/tpcd_div.sv
design/triangle_pixel_coverage_depth_test.sv
verif/triangle_pixel_coverage_depth_test_checker.sv
verif/triangle_pixel_coverage_depth_test_test.sv
